FILE: rtl/sexp_pkg.sv
// Package: shared types, constants and character classes of the S-expression lexer.
`default_nettype none
package sexp_pkg;

  localparam int VALUE_BITS = 32;
  localparam int MAG_BITS = VALUE_BITS - 1;
  localparam logic [MAG_BITS-1:0] MAG_LIMIT = {MAG_BITS{1'b1}};
  localparam int MAX_RESULTS = 3;
  localparam int CNT_BITS = $clog2(MAX_RESULTS + 1);
  localparam int IDX_BITS = $clog2(MAX_RESULTS);
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [3:0] KIND_CONST = 4'd0;
  localparam logic [3:0] KIND_OPEN = 4'd1;
  localparam logic [3:0] KIND_CLOSE = 4'd2;
  localparam logic [3:0] KIND_QUOTE = 4'd3;
  localparam logic [3:0] KIND_DOT = 4'd4;
  localparam logic [3:0] KIND_SCHAR = 4'd5;
  localparam logic [3:0] KIND_SEND = 4'd6;
  localparam logic [3:0] KIND_UNKNOWN = 4'd7;
  localparam logic [3:0] KIND_END = 4'd8;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_OPEN = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_LT = 8'h3C;
  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [7:0] byte_req;
    logic       end_of_input;
  } char_t;

  typedef struct packed {
    logic [3:0]                   kind;
    logic signed [VALUE_BITS-1:0] value;
    logic [7:0]                   symbol_byte;
    logic                         first_of_symbol;
    logic                         overflow;
    logic                         last;
  } tok_t;

  // All results caused by one input character.
  typedef struct packed {
    logic [CNT_BITS-1:0]         count;
    tok_t [MAX_RESULTS-1:0]      res;
  } batch_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_op_char(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_LT) || (c == CH_EQ) || (c == CH_GT) ||
           (c == CH_STAR) || (c == CH_SLASH) || (c == CH_HASH) || (c == CH_QMARK);
  endfunction

  function automatic logic sym_start(input logic [7:0] c);
    return is_alpha(c) || is_op_char(c);
  endfunction

  function automatic logic sym_cont(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || is_op_char(c) || (c == CH_MINUS) ||
           (c == CH_BANG);
  endfunction

  function automatic tok_t mk_tok(input logic [3:0] kind, input logic [7:0] b,
                                  input logic first);
    tok_t t;
    t = '0;
    t.kind = kind;
    t.symbol_byte = b;
    t.first_of_symbol = first;
    return t;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/sexp_front.sv
// Front end: lexer state, character classification and result batch building.
`default_nettype none
module sexp_front import sexp_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   char_valid,
  output logic        char_ready,
  input  wire char_t  char_data,
  input  wire logic   full,
  output logic        push,
  output batch_t      push_data
);

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_NUM = 2'd1;
  localparam logic [1:0] MODE_SYM = 2'd2;
  localparam logic [1:0] MODE_MINUS = 2'd3;

  logic [1:0]          mode, mode_next;
  logic [MAG_BITS-1:0] magnitude, magnitude_next;
  logic                negative, negative_next;
  logic                saturated, saturated_next;

  logic [7:0]          c;
  logic [MAG_BITS-1:0] digit;
  logic                idle_has, idle_num;
  tok_t                idle_tok;
  logic [1:0]          idle_mode;
  logic [MAG_BITS+3:0] prod;
  logic signed [VALUE_BITS-1:0] mag_ext;
  tok_t                const_tok;
  tok_t [MAX_RESULTS-1:0] slots;
  logic [CNT_BITS-1:0] n;
  logic                accept;

  assign c = char_data.byte_req;
  assign digit = MAG_BITS'(c[3:0]);
  assign char_ready = !full;
  assign accept = char_valid && char_ready;

  // Times ten plus digit as shift-adds; saturate past the magnitude limit.
  assign prod = ({4'b0, magnitude} << 3) + ({4'b0, magnitude} << 1) + {4'b0, digit};

  assign mag_ext = {1'b0, magnitude};

  always_comb begin
    const_tok = '0;
    const_tok.kind = KIND_CONST;
    const_tok.value = negative ? -mag_ext : mag_ext;
    const_tok.overflow = saturated;
  end

  // What a character does when no token is pending.
  always_comb begin
    idle_has = 1'b0;
    idle_num = 1'b0;
    idle_tok = '0;
    idle_mode = MODE_IDLE;
    priority if (is_space(c)) begin
      idle_has = 1'b0;
    end else if (is_digit(c)) begin
      idle_num = 1'b1;
      idle_mode = MODE_NUM;
    end else if (c == CH_MINUS) begin
      idle_mode = MODE_MINUS;
    end else if (c == CH_OPEN) begin
      idle_has = 1'b1;
      idle_tok = mk_tok(KIND_OPEN, 8'h00, 1'b0);
    end else if (c == CH_CLOSE) begin
      idle_has = 1'b1;
      idle_tok = mk_tok(KIND_CLOSE, 8'h00, 1'b0);
    end else if (sym_start(c)) begin
      idle_has = 1'b1;
      idle_tok = mk_tok(KIND_SCHAR, c, 1'b1);
      idle_mode = MODE_SYM;
    end else if (c == CH_QUOTE) begin
      idle_has = 1'b1;
      idle_tok = mk_tok(KIND_QUOTE, 8'h00, 1'b0);
    end else if (c == CH_DOT) begin
      idle_has = 1'b1;
      idle_tok = mk_tok(KIND_DOT, 8'h00, 1'b0);
    end else begin
      idle_has = 1'b1;
      idle_tok = mk_tok(KIND_UNKNOWN, c, 1'b0);
    end
  end

  always_comb begin
    mode_next = mode;
    magnitude_next = magnitude;
    negative_next = negative;
    saturated_next = saturated;
    slots = '0;
    n = '0;
    if (char_data.end_of_input) begin
      unique case (mode)
        MODE_NUM: begin
          slots[n] = const_tok;
          n = n + 1'b1;
        end
        MODE_SYM: begin
          slots[n] = mk_tok(KIND_SEND, 8'h00, 1'b0);
          n = n + 1'b1;
        end
        MODE_MINUS: begin
          slots[n] = mk_tok(KIND_SCHAR, CH_MINUS, 1'b1);
          n = n + 1'b1;
          slots[n] = mk_tok(KIND_SEND, 8'h00, 1'b0);
          n = n + 1'b1;
        end
        default: begin
          n = n;
        end
      endcase
      slots[n] = mk_tok(KIND_END, 8'h00, 1'b0);
      n = n + 1'b1;
      mode_next = MODE_IDLE;
      magnitude_next = '0;
      negative_next = 1'b0;
      saturated_next = 1'b0;
    end else begin
      unique case (mode)
        MODE_NUM: begin
          if (is_digit(c)) begin
            if (prod > (MAG_BITS + 4)'(MAG_LIMIT)) begin
              magnitude_next = MAG_LIMIT;
              saturated_next = 1'b1;
            end else begin
              magnitude_next = prod[MAG_BITS-1:0];
            end
          end else begin
            slots[n] = const_tok;
            n = n + 1'b1;
            negative_next = 1'b0;
            saturated_next = 1'b0;
            magnitude_next = idle_num ? digit : '0;
            mode_next = idle_mode;
            if (idle_has) begin
              slots[n] = idle_tok;
              n = n + 1'b1;
            end
          end
        end
        MODE_SYM: begin
          if (sym_cont(c)) begin
            slots[n] = mk_tok(KIND_SCHAR, c, 1'b0);
            n = n + 1'b1;
          end else begin
            slots[n] = mk_tok(KIND_SEND, 8'h00, 1'b0);
            n = n + 1'b1;
            mode_next = idle_mode;
            magnitude_next = idle_num ? digit : '0;
            if (idle_has) begin
              slots[n] = idle_tok;
              n = n + 1'b1;
            end
          end
        end
        MODE_MINUS: begin
          if (is_digit(c)) begin
            mode_next = MODE_NUM;
            magnitude_next = digit;
            negative_next = 1'b1;
            saturated_next = 1'b0;
          end else begin
            slots[n] = mk_tok(KIND_SCHAR, CH_MINUS, 1'b1);
            n = n + 1'b1;
            if (sym_cont(c)) begin
              mode_next = MODE_SYM;
              slots[n] = mk_tok(KIND_SCHAR, c, 1'b0);
              n = n + 1'b1;
            end else begin
              slots[n] = mk_tok(KIND_SEND, 8'h00, 1'b0);
              n = n + 1'b1;
              mode_next = idle_mode;
              magnitude_next = idle_num ? digit : '0;
              if (idle_has) begin
                slots[n] = idle_tok;
                n = n + 1'b1;
              end
            end
          end
        end
        default: begin
          mode_next = idle_mode;
          magnitude_next = idle_num ? digit : '0;
          negative_next = 1'b0;
          saturated_next = 1'b0;
          if (idle_has) begin
            slots[n] = idle_tok;
            n = n + 1'b1;
          end
        end
      endcase
    end
    if (n != '0) begin
      slots[n - 1'b1].last = 1'b1;
    end
  end

  assign push = accept && (n != '0);
  assign push_data.count = n;
  assign push_data.res = slots;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      magnitude <= '0;
      negative <= 1'b0;
      saturated <= 1'b0;
    end else if (accept) begin
      mode <= mode_next;
      magnitude <= magnitude_next;
      negative <= negative_next;
      saturated <= saturated_next;
    end
  end

  a_clean_outside_number: assert property (@(posedge clk) disable iff (rst)
    (mode != MODE_NUM) |-> (magnitude == '0 && !negative && !saturated))
    else $error("number state left over outside a number");

endmodule
`default_nettype wire

FILE: rtl/sexp_queue.sv
// Short batch queue between the lexer front end and the result serializer.
`default_nettype none
module sexp_queue import sexp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire batch_t push_data,
  output logic        full,
  input  wire logic   pop,
  output batch_t      head,
  output logic        empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);

  batch_t              store [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0]    count;

  assign full = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

FILE: rtl/sexp_back.sv
// Back end: walks each queued batch and drives results into the output register.
`default_nettype none
module sexp_back import sexp_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire batch_t head,
  input  wire logic   empty,
  output logic        pop,
  output logic        tok_valid,
  input  wire logic   tok_ready,
  output tok_t        tok_data
);

  logic [IDX_BITS-1:0] idx;
  logic                load, at_end;

  assign load = !empty && (!tok_valid || tok_ready);
  assign at_end = (CNT_BITS'(idx) == head.count - 1'b1);
  assign pop = load && at_end;

  always_ff @(posedge clk) begin
    if (load) begin
      tok_data <= head.res[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
      idx <= '0;
    end else begin
      if (load) begin
        tok_valid <= 1'b1;
        idx <= at_end ? '0 : idx + 1'b1;
      end else if (tok_ready) begin
        tok_valid <= 1'b0;
      end
    end
  end

  a_idx_in_batch: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (head.count != '0 && CNT_BITS'(idx) < head.count))
    else $error("result index outside queued batch");

endmodule
`default_nettype wire

FILE: rtl/s_expression_token_lexer_top.sv
// Top level of the S-expression token lexer: front end, batch queue, serializer.
// Path: results of an accepted character pass through the batch queue and then the
//   output register that drives tok_valid; each result is its own transaction.
// Throughput: while tok_ready stays high, one character per cycle if each yields at
//   most one result; results leave one per cycle and the queue absorbs bursts.
// Reset: synchronous rst returns the lexer to idle and empties queue and output.
`default_nettype none
module s_expression_token_lexer_top import sexp_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  // Character transaction in
  input  wire logic  char_valid,
  output logic       char_ready,
  input  wire char_t char_data,
  // Token transaction out
  output logic       tok_valid,
  input  wire logic  tok_ready,
  output tok_t       tok_data
);

  // Front to queue: one batch of up to three results per character.
  logic   push, full;
  batch_t push_data;
  // Queue to back.
  logic   pop, empty;
  batch_t head;

  // Classify each character and advance lexer state; stall only on a full queue.
  sexp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_data  (char_data),
    .full       (full),
    .push       (push),
    .push_data  (push_data)
  );

  // Hold batches so the front keeps lexing while the consumer stalls.
  sexp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  // Serialize each batch, one result per transaction, drop the batch on its last.
  sexp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok_data  (tok_data)
  );

endmodule
`default_nettype wire

FILE: bench/token_stream_checker.sv
// Token stream checker: predicts the lexer's results per character and compares them.
module token_stream_checker import sexp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  input  logic       char_ready,
  input  char_t      char_data,
  input  logic       tok_valid,
  input  logic       tok_ready,
  input  tok_t       tok_data,
  output int         failures,
  output int         outstanding,
  output int         chars_lexed,
  output int         tokens_checked,
  output int         saturated_seen,
  output logic [8:0] kinds_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {LEX_IDLE, LEX_NUMBER, LEX_SYMBOL, LEX_MINUS} lex_mode_e;

  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] LOWER_A = 8'h61;
  localparam logic [7:0] LOWER_Z = 8'h7A;
  localparam logic [7:0] UPPER_A = 8'h41;
  localparam logic [7:0] UPPER_Z = 8'h5A;

  lex_mode_e           mode;
  logic [MAG_BITS-1:0] mag;
  logic                neg;
  logic                sat;
  tok_t                step_tokens[$];
  tok_t                pending_tokens[$];

  function automatic logic digit_ch(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic letter_ch(logic [7:0] c);
    return (c >= LOWER_A && c <= LOWER_Z) || (c >= UPPER_A && c <= UPPER_Z);
  endfunction

  function automatic logic blank_ch(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic opens_symbol(logic [7:0] c);
    return letter_ch(c) ||
           c inside {CH_PLUS, CH_LT, CH_EQ, CH_GT, CH_STAR, CH_SLASH, CH_HASH, CH_QMARK};
  endfunction

  function automatic logic extends_symbol(logic [7:0] c);
    return opens_symbol(c) || digit_ch(c) || c == CH_MINUS || c == CH_BANG;
  endfunction

  function automatic void emit(logic [3:0] kind, logic [VALUE_BITS-1:0] val,
                               logic [7:0] b, logic first, logic ovf);
    tok_t t;
    t = '0;
    t.kind = kind;
    t.value = val;
    t.symbol_byte = b;
    t.first_of_symbol = first;
    t.overflow = ovf;
    step_tokens.push_back(t);
  endfunction

  function automatic void clear_state();
    mode = LEX_IDLE;
    mag = '0;
    neg = 1'b0;
    sat = 1'b0;
  endfunction

  function automatic void flush_number();
    logic [VALUE_BITS-1:0] v;
    v = {1'b0, mag};
    emit(KIND_CONST, neg ? -v : v, 8'h00, 1'b0, sat);
    clear_state();
  endfunction

  function automatic void from_idle(logic [7:0] c);
    if (blank_ch(c)) begin
      // whitespace between tokens yields nothing
    end else if (digit_ch(c)) begin
      mag = MAG_BITS'(c - CH_ZERO);
      neg = 1'b0;
      sat = 1'b0;
      mode = LEX_NUMBER;
    end else if (c == CH_MINUS) begin
      mode = LEX_MINUS;
    end else if (c == CH_OPEN) begin
      emit(KIND_OPEN, '0, 8'h00, 1'b0, 1'b0);
    end else if (c == CH_CLOSE) begin
      emit(KIND_CLOSE, '0, 8'h00, 1'b0, 1'b0);
    end else if (opens_symbol(c)) begin
      mode = LEX_SYMBOL;
      emit(KIND_SCHAR, '0, c, 1'b1, 1'b0);
    end else if (c == CH_QUOTE) begin
      emit(KIND_QUOTE, '0, 8'h00, 1'b0, 1'b0);
    end else if (c == CH_DOT) begin
      emit(KIND_DOT, '0, 8'h00, 1'b0, 1'b0);
    end else begin
      emit(KIND_UNKNOWN, '0, c, 1'b0, 1'b0);
    end
  endfunction

  function automatic void in_symbol(logic [7:0] c);
    if (extends_symbol(c)) begin
      emit(KIND_SCHAR, '0, c, 1'b0, 1'b0);
    end else begin
      emit(KIND_SEND, '0, 8'h00, 1'b0, 1'b0);
      mode = LEX_IDLE;
      from_idle(c);
    end
  endfunction

  // Work out every result one character causes and queue them in order.
  function automatic void lex_char(char_t ch);
    logic [7:0] c;
    longint unsigned d, m, lim;
    c = ch.byte_req;
    step_tokens.delete();
    if (ch.end_of_input) begin
      case (mode)
        LEX_NUMBER: flush_number();
        LEX_SYMBOL: emit(KIND_SEND, '0, 8'h00, 1'b0, 1'b0);
        LEX_MINUS: begin
          emit(KIND_SCHAR, '0, CH_MINUS, 1'b1, 1'b0);
          emit(KIND_SEND, '0, 8'h00, 1'b0, 1'b0);
        end
        default: ;
      endcase
      emit(KIND_END, '0, 8'h00, 1'b0, 1'b0);
      clear_state();
    end else begin
      case (mode)
        LEX_NUMBER: begin
          if (digit_ch(c)) begin
            d = 64'(c - CH_ZERO);
            m = 64'(mag);
            lim = 64'(MAG_LIMIT);
            if (m > (lim - d) / 10) begin
              mag = MAG_LIMIT;
              sat = 1'b1;
            end else begin
              mag = MAG_BITS'(m * 10 + d);
            end
          end else begin
            flush_number();
            from_idle(c);
          end
        end
        LEX_SYMBOL: in_symbol(c);
        LEX_MINUS: begin
          if (digit_ch(c)) begin
            mag = MAG_BITS'(c - CH_ZERO);
            neg = 1'b1;
            sat = 1'b0;
            mode = LEX_NUMBER;
          end else begin
            mode = LEX_SYMBOL;
            emit(KIND_SCHAR, '0, CH_MINUS, 1'b1, 1'b0);
            in_symbol(c);
          end
        end
        default: from_idle(c);
      endcase
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("token field %s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    tok_t want;
    if (rst) begin
      clear_state();
      pending_tokens.delete();
      failures = 0;
      chars_lexed = 0;
      tokens_checked = 0;
      saturated_seen = 0;
      kinds_seen = '0;
    end else begin
      // Compare first: a token leaving now never belongs to a character entering now.
      if (tok_valid && tok_ready) begin
        if (pending_tokens.size() == 0) begin
          $error("token of kind %0d arrived with nothing expected", tok_data.kind);
          failures++;
        end else begin
          want = pending_tokens.pop_front();
          check_field("kind", want.kind, tok_data.kind);
          check_field("value", $signed(want.value), $signed(tok_data.value));
          check_field("symbol_byte", want.symbol_byte, tok_data.symbol_byte);
          check_field("first_of_symbol", want.first_of_symbol, tok_data.first_of_symbol);
          check_field("overflow", want.overflow, tok_data.overflow);
          check_field("last", want.last, tok_data.last);
          tokens_checked++;
        end
        if (tok_data.kind <= KIND_END) kinds_seen[tok_data.kind] = 1'b1;
        if (tok_data.kind == KIND_CONST && tok_data.overflow) saturated_seen++;
      end
      if (char_valid && char_ready) begin
        lex_char(char_data);
        chars_lexed++;
      end
    end
    outstanding = pending_tokens.size();
  end

endmodule

FILE: bench/s_expression_token_lexer_top_test.sv
// Testbench top: feeds character streams to the S-expression lexer and reports the verdict.
module s_expression_token_lexer_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sexp_pkg::*;

  localparam int HOLD_CYCLES  = 120;   // long receiver hold-off, fills the block
  localparam int STALL_LIMIT  = 2000;  // cycles without any transaction before giving up
  localparam int DRAIN_CYCLES = 16;    // settle time once nothing is outstanding
  localparam int TARGET_ITEMS = 370;   // directed part plus random, all characters counted
  localparam int HOLD_AT      = 180;
  localparam int CALM_AFTER   = 320;
  localparam logic [7:0] CH_TAB = 8'h09;

  logic  clk;
  logic  rst;
  logic  char_valid;
  logic  char_ready;
  char_t char_data;
  logic  tok_valid;
  logic  tok_ready;
  tok_t  tok_data;

  int         failures;
  int         outstanding;
  int         chars_lexed;
  int         tokens_checked;
  int         saturated_seen;
  logic [8:0] kinds_seen;

  // idling and hold_tokens are shared by the sender and receiver; the counters are per process.
  logic idling = 1'b1;
  logic hold_tokens = 1'b0;
  int   lexed_items = 0;
  int   quiet_cycles = 0;

  string sym_first = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ+<=>*/#?";
  string sym_rest  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ+<=>*/#?0123456789-!";
  string digits    = "0123456789";

  s_expression_token_lexer_top dut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_data  (char_data),
    .tok_valid  (tok_valid),
    .tok_ready  (tok_ready),
    .tok_data   (tok_data)
  );

  token_stream_checker token_check (
    .clk            (clk),
    .rst            (rst),
    .char_valid     (char_valid),
    .char_ready     (char_ready),
    .char_data      (char_data),
    .tok_valid      (tok_valid),
    .tok_ready      (tok_ready),
    .tok_data       (tok_data),
    .failures       (failures),
    .outstanding    (outstanding),
    .chars_lexed    (chars_lexed),
    .tokens_checked (tokens_checked),
    .saturated_seen (saturated_seen),
    .kinds_seen     (kinds_seen)
  );

  // 4 ns clock.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Watchdog: end the run if no transaction moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (char_valid && char_ready) || (tok_valid && tok_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("s_expression_token_lexer_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  // Offer one character transaction. Drive on the falling edge, hold valid and
  // payload until the rising edge that sees ready. An optional idle burst comes
  // first; with no burst, valid stays high straight into the next transaction.
  task automatic send_char(input logic [7:0] b, input logic eoi, input logic counted);
    @(negedge clk);
    if (idling && $urandom_range(0, 7) == 0) begin
      char_valid = 1'b0;
      char_data = '0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    char_valid = 1'b1;
    char_data.byte_req = b;
    char_data.end_of_input = eoi;
    do @(posedge clk); while (!char_ready);
    if (counted) lexed_items++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0, 1'b1);
  endtask

  // End marker: the byte travels along but is meaningless, so randomize it.
  task automatic send_end();
    send_char(8'($urandom_range(0, 255)), 1'b1, 1'b1);
  endtask

  // One random lexeme. Most are well formed so the number and symbol paths get
  // exercised in depth; adjacent lexemes often touch with no separator.
  task automatic send_token();
    int n;
    case ($urandom_range(0, 19))
      0, 1, 2, 3: begin
        // whitespace: usually yields nothing, but still a character transaction
        send_char(($urandom_range(0, 2) == 0) ? CH_SPACE : CH_TAB + 8'($urandom_range(0, 4)),
                  1'b0, 1'b1);
      end
      4, 5, 6, 7, 8: begin
        if ($urandom_range(0, 3) == 0) send_char(CH_MINUS, 1'b0, 1'b1);
        // push toward the saturation boundary now and then
        if ($urandom_range(0, 9) == 0) send_text("214748364");
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 4);
        repeat (n) send_char(pick(digits), 1'b0, 1'b1);
      end
      9, 10, 11, 12: begin
        send_char(pick(sym_first), 1'b0, 1'b1);
        repeat ($urandom_range(0, 5)) send_char(pick(sym_rest), 1'b0, 1'b1);
      end
      13, 14, 15: begin
        case ($urandom_range(0, 3))
          0: send_char(CH_OPEN, 1'b0, 1'b1);
          1: send_char(CH_CLOSE, 1'b0, 1'b1);
          2: send_char(CH_QUOTE, 1'b0, 1'b1);
          default: send_char(CH_DOT, 1'b0, 1'b1);
        endcase
      end
      16: send_char(CH_MINUS, 1'b0, 1'b1);
      17, 18: send_char(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      default: send_end();
    endcase
  endtask

  // Receiver: random stalls, one long hold-off on request, none near the end.
  initial begin
    logic held;
    held = 1'b0;
    tok_ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_tokens && !held) begin
        held = 1'b1;
        tok_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (idling && $urandom_range(0, 5) == 0) begin
        tok_ready = 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      tok_ready = 1'b1;
    end
  end

  // Stimulus and verdict.
  initial begin
    logic hold_done;
    hold_done = 1'b0;
    rst = 1'b1;
    char_valid = 1'b0;
    char_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part.
    send_text("(a-1!)");   // brackets; symbol carrying a digit, a dash and a bang
    send_text("'x.");      // quote, then a dot that closes a symbol
    send_text("-(");       // dash before a bracket: dash symbol, its end and open at once
    send_text("-7 ");      // negative constant closed by whitespace
    send_char(8'hFF, 1'b0, 1'b1);     // top of the byte range: unknown
    send_char(8'h00, 1'b0, 1'b1);     // NUL: unknown
    send_char(8'h80, 1'b0, 1'b1);     // non-ASCII: unknown
    send_char(CH_BANG, 1'b0, 1'b1);   // bang outside a symbol: unknown
    send_text("-");
    send_end();            // lone dash flushed as a one-character symbol
    send_text("12");
    send_end();            // pending number flushed
    send_text("ab");
    send_end();            // pending symbol closed
    send_end();            // nothing pending: end result only

    // Random part.
    while (lexed_items < TARGET_ITEMS) begin
      if (lexed_items >= CALM_AFTER) begin
        idling = 1'b0;
      end else if ($urandom_range(0, 29) == 0) begin
        idling = !idling;
      end
      if (!hold_done && lexed_items >= HOLD_AT) begin
        hold_tokens = 1'b1;
        hold_done = 1'b1;
      end
      send_token();
    end
    send_end();
    @(negedge clk);
    char_valid = 1'b0;
    char_data = '0;

    // Drain: wait for every expected token, then allow for stray extras.
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Lexed %0d characters into %0d checked tokens, %0d of them saturated constants.",
             chars_lexed, tokens_checked, saturated_seen);
    $display("Token kinds observed, end marker down to constant: %b", kinds_seen);
    if (failures == 0 && outstanding == 0) begin
      $display("s_expression_token_lexer_top test passed");
    end else begin
      $display("s_expression_token_lexer_top test failed");
    end
    $finish;
  end

endmodule
